// ===== src/yuvq_pkg.sv =====
`default_nettype none

package yuvq_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CODE_W     = 16;
  localparam int LUMA_W     = 16;
  localparam int CHROMA_W   = 16;
  localparam int GAIN_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int FMT_W      = 2;
  localparam int CLAMP_W    = 2;

  localparam int DIFF_W = LUMA_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W;
  localparam int SUM_W  = PROD_W + 1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CODE_W-1:0]        code_t;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MODE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FROM_U  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FROM_V  = CFG_IDX_W'(7);

  localparam logic [FMT_W-1:0] FMT_RGB48 = FMT_W'(0);
  localparam logic [FMT_W-1:0] FMT_YCBCR = FMT_W'(1);
  localparam logic [FMT_W-1:0] FMT_GRAY  = FMT_W'(2);

  localparam logic [CLAMP_W-1:0] CLAMP_OFF   = CLAMP_W'(0);
  localparam logic [CLAMP_W-1:0] CLAMP_SDR   = CLAMP_W'(1);
  localparam logic [CLAMP_W-1:0] CLAMP_BT601 = CLAMP_W'(2);
  localparam logic [CLAMP_W-1:0] CLAMP_HDR   = CLAMP_W'(3);

  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << FRAC_BITS);

  localparam sum_t MAX_Q    = sum_t'(64'd65535 << FRAC_BITS);
  localparam sum_t HALF_Q   = sum_t'(64'd1 << (FRAC_BITS - 1));
  localparam sum_t Y_ZERO_Q = sum_t'(64'd4096 << FRAC_BITS);
  localparam sum_t C_ZERO_Q = sum_t'(64'd32768 << FRAC_BITS);

  localparam sum_t FULL_LO   = sum_t'(0);
  localparam sum_t FULL_HI   = sum_t'(65535);
  localparam sum_t SDR_Y_LO  = sum_t'(4096);
  localparam sum_t SDR_Y_HI  = sum_t'(60160);
  localparam sum_t SDR_C_LO  = sum_t'(4096);
  localparam sum_t SDR_C_HI  = sum_t'(61440);
  localparam sum_t BT601_LO  = sum_t'(256);
  localparam sum_t BT601_HI  = sum_t'(65216);

endpackage

`default_nettype wire

// ===== src/yuvq_pix_in_if.sv =====
`default_nettype none

interface yuvq_pix_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [yuvq_pkg::LUMA_W-1:0]   luma_in;
  logic signed [yuvq_pkg::CHROMA_W-1:0] u_in;
  logic signed [yuvq_pkg::CHROMA_W-1:0] v_in;

  modport source (output valid, output luma_in, output u_in, output v_in, input ready);
  modport sink (input valid, input luma_in, input u_in, input v_in, output ready);
endinterface

`default_nettype wire

// ===== src/yuvq_pix_out_if.sv =====
`default_nettype none

interface yuvq_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [yuvq_pkg::CODE_W-1:0]   first_component;
  logic [yuvq_pkg::CODE_W-1:0]   second_component;
  logic [yuvq_pkg::CODE_W-1:0]   third_component;

  modport source (
    output valid, output first_component, output second_component,
    output third_component, input ready
  );
  modport sink (
    input valid, input first_component, input second_component,
    input third_component, output ready
  );
endinterface

`default_nettype wire

// ===== src/yuvq_cfg_if.sv =====
`default_nettype none

interface yuvq_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [yuvq_pkg::CFG_IDX_W-1:0]    index;
  logic [yuvq_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/yuv_pixel_to_rgb_or_ycbcr_quantizer.sv =====
// Four register stages: a request accepted at a rising edge passes through them to the
// output register. Throughput is one request per cycle unless stalled; each stage advances
// when it is empty or its successor advances, so bubbles close up under output back-pressure.
// The stages are the five gain multipliers, the luma clamp and offset adds, the matrix
// sums and rounding, and the final clamp. Reset (synchronous, active low) empties the
// pipeline and loads the register defaults; configuration writes take effect at once.
`default_nettype none

module yuv_pixel_to_rgb_or_ycbcr_quantizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  yuvq_pix_in_if.sink     in_if,
  yuvq_pix_out_if.source  out_if,
  yuvq_cfg_if.sink        cfg_if
);

  logic [yuvq_pkg::FMT_W-1:0]          output_format_r;
  logic [yuvq_pkg::CLAMP_W-1:0]        clamp_mode_r;
  logic [yuvq_pkg::LUMA_W-1:0]         black_level_r;
  logic signed [yuvq_pkg::GAIN_W-1:0]  luma_gain_r;
  logic signed [yuvq_pkg::GAIN_W-1:0]  blue_gain_r;
  logic signed [yuvq_pkg::GAIN_W-1:0]  red_gain_r;
  logic signed [yuvq_pkg::GAIN_W-1:0]  green_from_u_r;
  logic signed [yuvq_pkg::GAIN_W-1:0]  green_from_v_r;

  logic en1, en2, en3, en_o;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;

  logic signed [yuvq_pkg::DIFF_W-1:0] diff;
  yuvq_pkg::prod_t p_l_nxt, p_r_nxt, p_gu_nxt, p_gv_nxt, p_b_nxt;
  yuvq_pkg::prod_t p_l_r, p_r_r, p_gu_r, p_gv_r, p_b_r;

  yuvq_pkg::sum_t ry_nxt, t0_nxt, t1_nxt, t2_nxt;
  yuvq_pkg::sum_t ry_r, t0_r, t1_r, t2_r;

  yuvq_pkg::sum_t c0_nxt, c1_nxt, c2_nxt;
  yuvq_pkg::sum_t c0_r, c1_r, c2_r;

  yuvq_pkg::sum_t y_lo, y_hi, c_lo, c_hi;
  yuvq_pkg::code_t comp0_nxt, comp1_nxt, comp2_nxt;
  yuvq_pkg::code_t comp0_r, comp1_r, comp2_r;

  function automatic yuvq_pkg::sum_t round_away(input yuvq_pkg::sum_t s);
    yuvq_pkg::sum_t t;
    t = s + yuvq_pkg::HALF_Q - yuvq_pkg::sum_t'({1'b0, s[yuvq_pkg::SUM_W-1]});
    return t >>> yuvq_pkg::FRAC_BITS;
  endfunction

  function automatic yuvq_pkg::code_t rgb_clamp(input yuvq_pkg::sum_t s);
    yuvq_pkg::code_t c;
    if (s < yuvq_pkg::FULL_LO) begin
      c = '0;
    end else if (s > yuvq_pkg::MAX_Q) begin
      c = '1;
    end else begin
      c = s[yuvq_pkg::FRAC_BITS +: yuvq_pkg::CODE_W];
    end
    return c;
  endfunction

  function automatic yuvq_pkg::code_t code_clamp(input yuvq_pkg::sum_t r,
                                                 input yuvq_pkg::sum_t lo,
                                                 input yuvq_pkg::sum_t hi);
    yuvq_pkg::code_t c;
    if (r < lo) begin
      c = lo[yuvq_pkg::CODE_W-1:0];
    end else if (r > hi) begin
      c = hi[yuvq_pkg::CODE_W-1:0];
    end else begin
      c = r[yuvq_pkg::CODE_W-1:0];
    end
    return c;
  endfunction

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_format_r <= yuvq_pkg::FMT_RGB48;
      clamp_mode_r    <= yuvq_pkg::CLAMP_OFF;
      black_level_r   <= '0;
      luma_gain_r     <= yuvq_pkg::GAIN_ONE;
      blue_gain_r     <= yuvq_pkg::GAIN_ONE;
      red_gain_r      <= yuvq_pkg::GAIN_ONE;
      green_from_u_r  <= '0;
      green_from_v_r  <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        yuvq_pkg::REG_OUTPUT_FORMAT: output_format_r <= cfg_if.data[yuvq_pkg::FMT_W-1:0];
        yuvq_pkg::REG_CLAMP_MODE:    clamp_mode_r    <= cfg_if.data[yuvq_pkg::CLAMP_W-1:0];
        yuvq_pkg::REG_BLACK_LEVEL:   black_level_r   <= cfg_if.data[yuvq_pkg::LUMA_W-1:0];
        yuvq_pkg::REG_LUMA_GAIN:     luma_gain_r     <= cfg_if.data;
        yuvq_pkg::REG_BLUE_GAIN:     blue_gain_r     <= cfg_if.data;
        yuvq_pkg::REG_RED_GAIN:      red_gain_r      <= cfg_if.data;
        yuvq_pkg::REG_GREEN_FROM_U:  green_from_u_r  <= cfg_if.data;
        yuvq_pkg::REG_GREEN_FROM_V:  green_from_v_r  <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  assign en_o = !out_valid_r || out_if.ready;
  assign en3  = !s3_valid_r || en_o;
  assign en2  = !s2_valid_r || en3;
  assign en1  = !s1_valid_r || en2;
  assign in_if.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_if.valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (en_o) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  assign diff = $signed({1'b0, in_if.luma_in}) - $signed({1'b0, black_level_r});

  assign p_l_nxt  = diff * luma_gain_r;
  assign p_r_nxt  = in_if.v_in * red_gain_r;
  assign p_gu_nxt = in_if.u_in * green_from_u_r;
  assign p_gv_nxt = in_if.v_in * green_from_v_r;
  assign p_b_nxt  = in_if.u_in * blue_gain_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_l_r  <= p_l_nxt;
      p_r_r  <= p_r_nxt;
      p_gu_r <= p_gu_nxt;
      p_gv_r <= p_gv_nxt;
      p_b_r  <= p_b_nxt;
    end
  end

  always_comb begin
    if (p_l_r < yuvq_pkg::prod_t'(0)) begin
      ry_nxt = '0;
    end else if (yuvq_pkg::sum_t'(p_l_r) > yuvq_pkg::MAX_Q) begin
      ry_nxt = yuvq_pkg::MAX_Q;
    end else begin
      ry_nxt = yuvq_pkg::sum_t'(p_l_r);
    end
    if (output_format_r == yuvq_pkg::FMT_RGB48) begin
      t0_nxt = yuvq_pkg::sum_t'(p_r_r);
      t1_nxt = yuvq_pkg::sum_t'(p_gu_r) + yuvq_pkg::sum_t'(p_gv_r);
      t2_nxt = yuvq_pkg::sum_t'(p_b_r);
    end else begin
      t0_nxt = yuvq_pkg::sum_t'(p_l_r) + yuvq_pkg::Y_ZERO_Q;
      t1_nxt = yuvq_pkg::sum_t'(p_b_r) + yuvq_pkg::C_ZERO_Q;
      t2_nxt = yuvq_pkg::sum_t'(p_r_r) + yuvq_pkg::C_ZERO_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ry_r <= ry_nxt;
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
    end
  end

  always_comb begin
    if (output_format_r == yuvq_pkg::FMT_RGB48) begin
      c0_nxt = ry_r + t0_r;
      c1_nxt = ry_r + t1_r;
      c2_nxt = ry_r + t2_r;
    end else begin
      c0_nxt = round_away(t0_r);
      c1_nxt = round_away(t1_r);
      c2_nxt = round_away(t2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      c0_r <= c0_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  always_comb begin
    case (clamp_mode_r)
      yuvq_pkg::CLAMP_SDR: begin
        y_lo = yuvq_pkg::SDR_Y_LO;
        y_hi = yuvq_pkg::SDR_Y_HI;
        c_lo = yuvq_pkg::SDR_C_LO;
        c_hi = yuvq_pkg::SDR_C_HI;
      end
      yuvq_pkg::CLAMP_BT601: begin
        y_lo = yuvq_pkg::BT601_LO;
        y_hi = yuvq_pkg::BT601_HI;
        c_lo = yuvq_pkg::BT601_LO;
        c_hi = yuvq_pkg::BT601_HI;
      end
      yuvq_pkg::CLAMP_OFF, yuvq_pkg::CLAMP_HDR: begin
        y_lo = yuvq_pkg::FULL_LO;
        y_hi = yuvq_pkg::FULL_HI;
        c_lo = yuvq_pkg::FULL_LO;
        c_hi = yuvq_pkg::FULL_HI;
      end
      default: begin
        y_lo = yuvq_pkg::FULL_LO;
        y_hi = yuvq_pkg::FULL_HI;
        c_lo = yuvq_pkg::FULL_LO;
        c_hi = yuvq_pkg::FULL_HI;
      end
    endcase
  end

  always_comb begin
    case (output_format_r)
      yuvq_pkg::FMT_RGB48: begin
        comp0_nxt = rgb_clamp(c0_r);
        comp1_nxt = rgb_clamp(c1_r);
        comp2_nxt = rgb_clamp(c2_r);
      end
      yuvq_pkg::FMT_YCBCR: begin
        comp0_nxt = code_clamp(c0_r, y_lo, y_hi);
        comp1_nxt = code_clamp(c1_r, c_lo, c_hi);
        comp2_nxt = code_clamp(c2_r, c_lo, c_hi);
      end
      yuvq_pkg::FMT_GRAY: begin
        comp0_nxt = code_clamp(c0_r, y_lo, y_hi);
        comp1_nxt = '0;
        comp2_nxt = '0;
      end
      default: begin
        comp0_nxt = '0;
        comp1_nxt = '0;
        comp2_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      comp0_r <= comp0_nxt;
      comp1_r <= comp1_nxt;
      comp2_r <= comp2_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.first_component  = comp0_r;
  assign out_if.second_component = comp1_r;
  assign out_if.third_component  = comp2_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_yuv_pixel_to_rgb_or_ycbcr_quantizer.sv =====
`default_nettype none

module tb_yuv_pixel_to_rgb_or_ycbcr_quantizer;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 14;
  localparam int PIXELS_PER_PHASE = 110;
  localparam int REG_COUNT = 8;
  localparam int IDLE_PCT = 35;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [yuvq_pkg::FMT_W-1:0] FMT_UNUSED = yuvq_pkg::FMT_W'(3);

  localparam longint Y_ZERO_CODE = 4096;
  localparam longint C_ZERO_CODE = 32768;
  localparam longint CODE_TOP = 65535;
  localparam longint HALF_LSB = longint'(1) <<< (yuvq_pkg::FRAC_BITS - 1);

  localparam logic signed [yuvq_pkg::GAIN_W-1:0] GAIN_MIN =
    {1'b1, {(yuvq_pkg::GAIN_W-1){1'b0}}};
  localparam logic signed [yuvq_pkg::GAIN_W-1:0] GAIN_MAX =
    {1'b0, {(yuvq_pkg::GAIN_W-1){1'b1}}};
  localparam logic signed [yuvq_pkg::GAIN_W-1:0] GAIN_HALF = yuvq_pkg::GAIN_ONE >>> 1;

  typedef struct {
    logic [yuvq_pkg::LUMA_W-1:0]          luma;
    logic signed [yuvq_pkg::CHROMA_W-1:0] u;
    logic signed [yuvq_pkg::CHROMA_W-1:0] v;
  } pixel_req_t;

  typedef struct packed {
    yuvq_pkg::code_t first_c;
    yuvq_pkg::code_t second_c;
    yuvq_pkg::code_t third_c;
  } pixel_codes_t;

  logic clk;
  logic rst_n;

  yuvq_pix_in_if  pix_in ();
  yuvq_pix_out_if pix_out ();
  yuvq_cfg_if     cfg ();

  yuv_pixel_to_rgb_or_ycbcr_quantizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_in),
    .out_if (pix_out),
    .cfg_if (cfg)
  );

  // Register copies used by the predictor.
  logic [yuvq_pkg::FMT_W-1:0]          cur_fmt;
  logic [yuvq_pkg::CLAMP_W-1:0]        cur_clamp;
  logic [yuvq_pkg::LUMA_W-1:0]         cur_black;
  logic signed [yuvq_pkg::GAIN_W-1:0]  cur_luma_gain;
  logic signed [yuvq_pkg::GAIN_W-1:0]  cur_blue_gain;
  logic signed [yuvq_pkg::GAIN_W-1:0]  cur_red_gain;
  logic signed [yuvq_pkg::GAIN_W-1:0]  cur_green_u;
  logic signed [yuvq_pkg::GAIN_W-1:0]  cur_green_v;

  pixel_req_t   pixel_q[$];
  pixel_codes_t codes_q[$];

  int  in_idle_pct;
  int  out_idle_pct;
  bit  pixel_taken;
  int  mismatches;
  int  codes_seen;
  int  settings_used;
  int  per_format[4];
  int  cycle_count;

  always #5 clk = ~clk;

  function automatic longint clamp_range(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic yuvq_pkg::code_t rgb_code(longint q);
    return yuvq_pkg::code_t'(clamp_range(q, 0, CODE_TOP <<< yuvq_pkg::FRAC_BITS) >>>
                             yuvq_pkg::FRAC_BITS);
  endfunction

  function automatic yuvq_pkg::code_t quant_code(longint scaled, longint zero_code,
                                                 longint lo, longint hi);
    longint t;
    longint r;
    t = scaled + (zero_code <<< yuvq_pkg::FRAC_BITS);
    if (t >= 0) begin
      r = (t + HALF_LSB) >>> yuvq_pkg::FRAC_BITS;
    end else begin
      r = -((-t + HALF_LSB) >>> yuvq_pkg::FRAC_BITS);
    end
    return yuvq_pkg::code_t'(clamp_range(r, lo, hi));
  endfunction

  function automatic pixel_codes_t convert_pixel(pixel_req_t p);
    longint d;
    longint su;
    longint sv;
    longint ry;
    longint ylo;
    longint yhi;
    longint clo;
    longint chi;
    pixel_codes_t r;
    d = longint'(p.luma) - longint'(cur_black);
    su = longint'(p.u);
    sv = longint'(p.v);
    ylo = longint'(yuvq_pkg::FULL_LO);
    yhi = longint'(yuvq_pkg::FULL_HI);
    clo = longint'(yuvq_pkg::FULL_LO);
    chi = longint'(yuvq_pkg::FULL_HI);
    if (cur_clamp == yuvq_pkg::CLAMP_SDR) begin
      ylo = longint'(yuvq_pkg::SDR_Y_LO);
      yhi = longint'(yuvq_pkg::SDR_Y_HI);
      clo = longint'(yuvq_pkg::SDR_C_LO);
      chi = longint'(yuvq_pkg::SDR_C_HI);
    end else if (cur_clamp == yuvq_pkg::CLAMP_BT601) begin
      ylo = longint'(yuvq_pkg::BT601_LO);
      yhi = longint'(yuvq_pkg::BT601_HI);
      clo = longint'(yuvq_pkg::BT601_LO);
      chi = longint'(yuvq_pkg::BT601_HI);
    end
    r = '0;
    case (cur_fmt)
      yuvq_pkg::FMT_RGB48: begin
        ry = clamp_range(d * longint'(cur_luma_gain), 0, CODE_TOP <<< yuvq_pkg::FRAC_BITS);
        r.first_c = rgb_code(ry + longint'(cur_red_gain) * sv);
        r.second_c = rgb_code(ry + longint'(cur_green_u) * su + longint'(cur_green_v) * sv);
        r.third_c = rgb_code(ry + longint'(cur_blue_gain) * su);
      end
      yuvq_pkg::FMT_YCBCR: begin
        r.first_c = quant_code(d * longint'(cur_luma_gain), Y_ZERO_CODE, ylo, yhi);
        r.second_c = quant_code(su * longint'(cur_blue_gain), C_ZERO_CODE, clo, chi);
        r.third_c = quant_code(sv * longint'(cur_red_gain), C_ZERO_CODE, clo, chi);
      end
      yuvq_pkg::FMT_GRAY: begin
        r.first_c = quant_code(d * longint'(cur_luma_gain), Y_ZERO_CODE, ylo, yhi);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Request and register tracking, and result checking, at the rising edge.
  always @(posedge clk) begin
    pixel_req_t   req;
    pixel_codes_t exp_c;
    pixel_taken = 1'b0;
    if (rst_n) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          yuvq_pkg::REG_OUTPUT_FORMAT: cur_fmt = cfg.data[yuvq_pkg::FMT_W-1:0];
          yuvq_pkg::REG_CLAMP_MODE:    cur_clamp = cfg.data[yuvq_pkg::CLAMP_W-1:0];
          yuvq_pkg::REG_BLACK_LEVEL:   cur_black = cfg.data[yuvq_pkg::LUMA_W-1:0];
          yuvq_pkg::REG_LUMA_GAIN:     cur_luma_gain = cfg.data;
          yuvq_pkg::REG_BLUE_GAIN:     cur_blue_gain = cfg.data;
          yuvq_pkg::REG_RED_GAIN:      cur_red_gain = cfg.data;
          yuvq_pkg::REG_GREEN_FROM_U:  cur_green_u = cfg.data;
          yuvq_pkg::REG_GREEN_FROM_V:  cur_green_v = cfg.data;
          default: begin
          end
        endcase
      end
      if (pix_in.valid && pix_in.ready) begin
        pixel_taken = 1'b1;
        req.luma = pix_in.luma_in;
        req.u = pix_in.u_in;
        req.v = pix_in.v_in;
        codes_q = {codes_q, convert_pixel(req)};
        per_format[cur_fmt]++;
      end
      if (pix_out.valid && pix_out.ready) begin
        codes_seen++;
        if (codes_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result %h %h %h", $time, pix_out.first_component,
                   pix_out.second_component, pix_out.third_component);
        end else begin
          exp_c = codes_q.pop_front();
          if (pix_out.first_component !== exp_c.first_c) begin
            mismatches++;
            $display("%0t: first_component expected %h actual %h", $time, exp_c.first_c,
                     pix_out.first_component);
          end
          if (pix_out.second_component !== exp_c.second_c) begin
            mismatches++;
            $display("%0t: second_component expected %h actual %h", $time, exp_c.second_c,
                     pix_out.second_component);
          end
          if (pix_out.third_component !== exp_c.third_c) begin
            mismatches++;
            $display("%0t: third_component expected %h actual %h", $time, exp_c.third_c,
                     pix_out.third_component);
          end
        end
      end
    end
  end

  // Pixel driver and result back-pressure at the falling edge.
  always @(negedge clk) begin
    pixel_req_t nxt;
    if (rst_n && (!pix_in.valid || pixel_taken)) begin
      if (pixel_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        nxt = pixel_q.pop_front();
        pix_in.valid <= 1'b1;
        pix_in.luma_in <= nxt.luma;
        pix_in.u_in <= nxt.u;
        pix_in.v_in <= nxt.v;
      end else begin
        pix_in.valid <= 1'b0;
      end
    end
    pix_out.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, codes_q.size());
      $display("tb_yuv_pixel_to_rgb_or_ycbcr_quantizer NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [yuvq_pkg::CFG_IDX_W-1:0] idx,
                           logic [yuvq_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Unused upper data bits are filled with noise; the block must ignore them.
  task automatic set_regs(logic [yuvq_pkg::FMT_W-1:0] fmt,
                          logic [yuvq_pkg::CLAMP_W-1:0] clamp,
                          logic [yuvq_pkg::LUMA_W-1:0] black,
                          logic signed [yuvq_pkg::GAIN_W-1:0] lg,
                          logic signed [yuvq_pkg::GAIN_W-1:0] bg,
                          logic signed [yuvq_pkg::GAIN_W-1:0] rg,
                          logic signed [yuvq_pkg::GAIN_W-1:0] gu,
                          logic signed [yuvq_pkg::GAIN_W-1:0] gv);
    logic [yuvq_pkg::CFG_DATA_W-1:0] noise;
    noise = $urandom();
    write_reg(yuvq_pkg::REG_OUTPUT_FORMAT,
              {noise[yuvq_pkg::CFG_DATA_W-1:yuvq_pkg::FMT_W], fmt});
    noise = $urandom();
    write_reg(yuvq_pkg::REG_CLAMP_MODE,
              {noise[yuvq_pkg::CFG_DATA_W-1:yuvq_pkg::CLAMP_W], clamp});
    noise = $urandom();
    write_reg(yuvq_pkg::REG_BLACK_LEVEL,
              {noise[yuvq_pkg::CFG_DATA_W-1:yuvq_pkg::LUMA_W], black});
    write_reg(yuvq_pkg::REG_LUMA_GAIN, lg);
    write_reg(yuvq_pkg::REG_BLUE_GAIN, bg);
    write_reg(yuvq_pkg::REG_RED_GAIN, rg);
    write_reg(yuvq_pkg::REG_GREEN_FROM_U, gu);
    write_reg(yuvq_pkg::REG_GREEN_FROM_V, gv);
    settings_used++;
  endtask

  task automatic queue_pixel(logic [yuvq_pkg::LUMA_W-1:0] luma,
                             logic signed [yuvq_pkg::CHROMA_W-1:0] u,
                             logic signed [yuvq_pkg::CHROMA_W-1:0] v);
    pixel_req_t p;
    p.luma = luma;
    p.u = u;
    p.v = v;
    pixel_q = {pixel_q, p};
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pixel_q.size() != 0 || pix_in.valid || codes_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [yuvq_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(9))
      0: return GAIN_MIN;
      1: return GAIN_MAX;
      2: return '0;
      3: return $urandom();
      default: return yuvq_pkg::GAIN_W'($urandom_range(524288)) - (yuvq_pkg::GAIN_ONE <<< 2);
    endcase
  endfunction

  function automatic logic signed [yuvq_pkg::CHROMA_W-1:0] pick_chroma();
    case ($urandom_range(5))
      0: return {1'b1, {(yuvq_pkg::CHROMA_W-1){1'b0}}};
      1: return {1'b0, {(yuvq_pkg::CHROMA_W-1){1'b1}}};
      2: return yuvq_pkg::CHROMA_W'($urandom_range(8192)) - yuvq_pkg::CHROMA_W'(4096);
      default: return yuvq_pkg::CHROMA_W'($urandom());
    endcase
  endfunction

  function automatic logic [yuvq_pkg::LUMA_W-1:0] pick_luma();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return cur_black + yuvq_pkg::LUMA_W'($urandom_range(512)) - yuvq_pkg::LUMA_W'(256);
      default: return yuvq_pkg::LUMA_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [yuvq_pkg::FMT_W-1:0] fmt;
    logic [yuvq_pkg::CFG_IDX_W-1:0] bad_idx;
    clk = 1'b0;
    rst_n = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.luma_in = '0;
    pix_in.u_in = '0;
    pix_in.v_in = '0;
    pix_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
    mismatches = 0;
    codes_seen = 0;
    settings_used = 0;
    cycle_count = 0;
    per_format = '{default: 0};
    cur_fmt = yuvq_pkg::FMT_RGB48;
    cur_clamp = yuvq_pkg::CLAMP_OFF;
    cur_black = '0;
    cur_luma_gain = yuvq_pkg::GAIN_ONE;
    cur_blue_gain = yuvq_pkg::GAIN_ONE;
    cur_red_gain = yuvq_pkg::GAIN_ONE;
    cur_green_u = '0;
    cur_green_v = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: RGB48 with unit gains and no green terms.
    queue_pixel('0, '0, '0);
    queue_pixel('1, 16'sh7fff, 16'sh7fff);
    queue_pixel('1, 16'sh8000, 16'sh8000);
    queue_pixel('0, 16'sh8000, 16'sh7fff);
    queue_pixel(16'h8000, -16'sd1, 16'sd1);
    wait_drained();

    // RGB48 with extreme matrix terms.
    set_regs(yuvq_pkg::FMT_RGB48, yuvq_pkg::CLAMP_SDR, '0, GAIN_MAX, GAIN_MAX, GAIN_MIN,
             GAIN_MIN, GAIN_MAX);
    queue_pixel('1, 16'sh8000, 16'sh7fff);
    queue_pixel(16'd1, 16'sh7fff, 16'sh8000);
    queue_pixel('0, '0, '0);
    wait_drained();

    // Exact halves: rounding away from zero on both sides of zero.
    set_regs(yuvq_pkg::FMT_YCBCR, yuvq_pkg::CLAMP_SDR, 16'd4096, GAIN_HALF,
             yuvq_pkg::GAIN_ONE + 1, -GAIN_HALF, '0, '0);
    queue_pixel(16'd4097, '0, '0);
    queue_pixel(16'd4095, 16'sh8000, 16'sh8000);
    queue_pixel('1, 16'sh7fff, 16'sh7fff);
    queue_pixel('0, -16'sd1, 16'sd1);
    wait_drained();
    set_regs(yuvq_pkg::FMT_YCBCR, yuvq_pkg::CLAMP_OFF, 16'd4096, GAIN_HALF,
             yuvq_pkg::GAIN_ONE + 1, -GAIN_HALF, '0, '0);
    queue_pixel(16'd4095, 16'sh8000, '0);
    wait_drained();
    set_regs(yuvq_pkg::FMT_YCBCR, yuvq_pkg::CLAMP_BT601, '0, yuvq_pkg::GAIN_ONE,
             yuvq_pkg::GAIN_ONE, yuvq_pkg::GAIN_ONE, '0, '0);
    queue_pixel('1, 16'sh7fff, 16'sh8000);
    queue_pixel('0, 16'sh8000, 16'sh7fff);
    wait_drained();
    set_regs(yuvq_pkg::FMT_YCBCR, yuvq_pkg::CLAMP_HDR, '0, yuvq_pkg::GAIN_ONE, GAIN_MAX,
             GAIN_MIN, '0, '0);
    queue_pixel('1, 16'sh7fff, 16'sh7fff);
    wait_drained();

    // Gray ignores chroma; extreme black level and gains.
    set_regs(yuvq_pkg::FMT_GRAY, yuvq_pkg::CLAMP_BT601, '1, GAIN_MAX, yuvq_pkg::GAIN_ONE,
             yuvq_pkg::GAIN_ONE, '0, '0);
    queue_pixel('0, 16'sh7fff, 16'sh8000);
    queue_pixel('1, 16'sh8000, 16'sh7fff);
    wait_drained();
    set_regs(yuvq_pkg::FMT_GRAY, yuvq_pkg::CLAMP_OFF, '1, GAIN_MIN, yuvq_pkg::GAIN_ONE,
             yuvq_pkg::GAIN_ONE, '0, '0);
    queue_pixel('0, 16'sh1234, -16'sd1);
    wait_drained();

    // The unused format code gives zeros, and writes past the last register are ignored.
    set_regs(FMT_UNUSED, yuvq_pkg::CLAMP_SDR, 16'd100, yuvq_pkg::GAIN_ONE,
             yuvq_pkg::GAIN_ONE, yuvq_pkg::GAIN_ONE, '0, '0);
    bad_idx = yuvq_pkg::CFG_IDX_W'($urandom_range(2 ** yuvq_pkg::CFG_IDX_W - 1, REG_COUNT));
    write_reg(bad_idx, {{(yuvq_pkg::CFG_DATA_W-yuvq_pkg::FMT_W){1'b0}}, yuvq_pkg::FMT_GRAY});
    queue_pixel('1, 16'sh7fff, 16'sh8000);
    queue_pixel(16'd5000, 16'sd77, -16'sd77);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 7 == 6) begin
        fmt = FMT_UNUSED;
      end else begin
        fmt = yuvq_pkg::FMT_W'(ph % 3);
      end
      set_regs(fmt, yuvq_pkg::CLAMP_W'($urandom_range(3)),
               ($urandom_range(3) == 0) ? yuvq_pkg::LUMA_W'($urandom()) :
                                          yuvq_pkg::LUMA_W'($urandom_range(20000)),
               pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain());
      if ($urandom_range(3) == 0) begin
        bad_idx = yuvq_pkg::CFG_IDX_W'($urandom_range(2 ** yuvq_pkg::CFG_IDX_W - 1,
                                                      REG_COUNT));
        write_reg(bad_idx, $urandom());
      end
      // One stretch runs with both sides at full rate.
      in_idle_pct = (ph == 4) ? 0 : IDLE_PCT;
      out_idle_pct = (ph == 4) ? 0 : IDLE_PCT;
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        queue_pixel(pick_luma(), pick_chroma(), pick_chroma());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d pixel results under %0d register settings.", codes_seen,
             settings_used);
    $display("Requests per format: RGB48 %0d, YCbCr %0d, gray %0d, unused code %0d.",
             per_format[0], per_format[1], per_format[2], per_format[3]);
    if (mismatches == 0 && codes_q.size() == 0) begin
      $display("tb_yuv_pixel_to_rgb_or_ycbcr_quantizer OK");
    end else begin
      $display("tb_yuv_pixel_to_rgb_or_ycbcr_quantizer NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/yuvq_pkg.sv
src/yuvq_pix_in_if.sv
src/yuvq_pix_out_if.sv
src/yuvq_cfg_if.sv
src/yuv_pixel_to_rgb_or_ycbcr_quantizer.sv
tb/sv/tb_yuv_pixel_to_rgb_or_ycbcr_quantizer.sv
